FILE: hdl/ssb_pkg.sv
package ssb_pkg;

  // field widths
  localparam int unsigned AXIS_W = 12;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned AXES   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_TH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_TH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRECT_WIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EN   = 3'd6;

  // register reset values
  localparam logic [AXIS_W-1:0] CENTER_RST      = 12'd2048;
  localparam logic [AXIS_W-1:0] LARGE_TH_RST    = 12'd2000;
  localparam logic [AXIS_W-1:0] SMALL_TH_RST    = 12'd1200;
  localparam logic [TIME_W-1:0] RELEASE_WIN_RST = 32'd5000;
  localparam logic [TIME_W-1:0] CORRECT_WIN_RST = 32'd10000;

  // axis slots, left stick first
  localparam int unsigned AX_LX = 0;
  localparam int unsigned AX_LY = 1;
  localparam int unsigned AX_RX = 2;
  localparam int unsigned AX_RY = 3;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
  } sample_t;

  typedef struct packed {
    logic [AXIS_W-1:0] out_left_x;
    logic [AXIS_W-1:0] out_left_y;
    logic [AXIS_W-1:0] out_right_x;
    logic [AXIS_W-1:0] out_right_y;
  } result_t;

endpackage

FILE: hdl/ssb_sample_if.sv
interface ssb_sample_if;
  import ssb_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

FILE: hdl/ssb_result_if.sv
interface ssb_result_if;
  import ssb_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

FILE: hdl/stick_snapback_suppressor.sv
// channel   | dir | payload                                   | transfer
// ----------+-----+-------------------------------------------+-------------------
// sample_i  | in  | sample_time, left_x, left_y, right_x/y    | valid & ready
// result_o  | out | out_left_x, out_left_y, out_right_x/y     | valid & ready
// cfg       | in  | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// one sample per cycle sustained while result_o.ready stays high; a transferred sample
// passes the input register, then the per-axis compare logic into the result register,
// where the result becomes valid
// the per-axis state updates when a sample moves into the result register
// reset (rst_ni low, asynchronous) clears the axis state and loads default config
// a stalled result holds its register; an empty input register still takes one sample
module stick_snapback_suppressor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ssb_sample_if.sink                      sample_i,
  ssb_result_if.source                    result_o
);
  import ssb_pkg::*;

  // configuration registers
  logic [AXIS_W-1:0] center_q;
  logic [AXIS_W-1:0] large_th_q;
  logic [AXIS_W-1:0] small_th_q;
  logic [TIME_W-1:0] release_win_q;
  logic [TIME_W-1:0] correct_win_q;
  logic              left_en_q;
  logic              right_en_q;

  // per-axis state
  logic [AXES-1:0][TIME_W-1:0] last_large_q, last_large_d;
  logic [AXES-1:0][TIME_W-1:0] corr_begin_q, corr_begin_d;
  logic [AXES-1:0]             correcting_q, correcting_d;

  // pipeline registers
  logic    in_vld_q;
  sample_t in_data_q;
  logic    out_vld_q;
  result_t out_data_q, out_data_d;

  logic                        advance;
  logic [AXES-1:0][AXIS_W-1:0] pos;
  logic [AXES-1:0][AXIS_W-1:0] axis_out;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q      <= CENTER_RST;
      large_th_q    <= LARGE_TH_RST;
      small_th_q    <= SMALL_TH_RST;
      release_win_q <= RELEASE_WIN_RST;
      correct_win_q <= CORRECT_WIN_RST;
      left_en_q     <= 1'b1;
      right_en_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER:      center_q      <= cfg_data_i[AXIS_W-1:0];
        CFG_LARGE_TH:    large_th_q    <= cfg_data_i[AXIS_W-1:0];
        CFG_SMALL_TH:    small_th_q    <= cfg_data_i[AXIS_W-1:0];
        CFG_RELEASE_WIN: release_win_q <= cfg_data_i[TIME_W-1:0];
        CFG_CORRECT_WIN: correct_win_q <= cfg_data_i[TIME_W-1:0];
        CFG_LEFT_EN:     left_en_q     <= cfg_data_i[0];
        CFG_RIGHT_EN:    right_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: input register moves on when the result register is free
  assign advance        = in_vld_q && (!out_vld_q || result_o.ready);
  assign sample_i.ready = !in_vld_q || advance;
  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_data_q <= sample_i.data;
    end
  end

  // axis positions in slot order
  assign pos[AX_LX] = in_data_q.left_x;
  assign pos[AX_LY] = in_data_q.left_y;
  assign pos[AX_RX] = in_data_q.right_x;
  assign pos[AX_RY] = in_data_q.right_y;

  // per-axis snapback logic
  for (genvar k = 0; k < AXES; k++) begin : g_axis
    localparam bit LeftStick = (k < AXES / 2);

    logic              en;
    logic [AXIS_W-1:0] offset;
    logic              is_large;
    logic              is_small;
    logic [TIME_W-1:0] since_large;
    logic [TIME_W-1:0] since_begin;

    assign en = LeftStick ? left_en_q : right_en_q;

    always_comb begin
      offset = (pos[k] >= center_q) ? (pos[k] - center_q) : (center_q - pos[k]);
      is_large = (offset >= large_th_q);
      is_small = (offset <= small_th_q);
      // a large deflection in this sample refreshes the large time first
      since_large = is_large ? '0 : (in_data_q.sample_time - last_large_q[k]);
      since_begin = in_data_q.sample_time - corr_begin_q[k];

      last_large_d[k] = last_large_q[k];
      corr_begin_d[k] = corr_begin_q[k];
      correcting_d[k] = correcting_q[k];

      if (en) begin
        if (is_large) begin
          last_large_d[k] = in_data_q.sample_time;
        end
        if (is_small) begin
          if (correcting_q[k]) begin
            if (since_begin > correct_win_q) begin
              correcting_d[k] = 1'b0;
            end
          end else if (since_large <= release_win_q) begin
            correcting_d[k] = 1'b1;
            corr_begin_d[k] = in_data_q.sample_time;
          end
        end else begin
          correcting_d[k] = 1'b0;
        end
      end

      axis_out[k] = (!en || correcting_d[k]) ? center_q : pos[k];
    end
  end

  // pack result
  always_comb begin
    out_data_d.out_left_x  = axis_out[AX_LX];
    out_data_d.out_left_y  = axis_out[AX_LY];
    out_data_d.out_right_x = axis_out[AX_RX];
    out_data_d.out_right_y = axis_out[AX_RY];
  end

  // state commits when a sample moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_large_q <= '0;
      corr_begin_q <= '0;
      correcting_q <= '0;
    end else if (advance) begin
      last_large_q <= last_large_d;
      corr_begin_q <= corr_begin_d;
      correcting_q <= correcting_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: hdl/ssb_checker.sv
module ssb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             sample_valid_i,
  input logic             sample_ready_i,
  input logic             result_valid_i,
  input logic             result_ready_i,
  input ssb_pkg::result_t result_data_i
);

  // a pending result holds until its transfer
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=> result_valid_i)
    else $error("result dropped before transfer");

  // a stalled result keeps its payload
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=> $stable(result_data_i))
    else $error("stalled result changed");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_i |-> sample_ready_i)
    else $error("input stalled with empty result register");

  // a sample transfer is followed by a valid result on the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_i |-> ##2 result_valid_i)
    else $error("no result after sample transfer");

endmodule

bind stick_snapback_suppressor ssb_checker u_ssb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_valid_i (sample_i.valid),
  .sample_ready_i (sample_i.ready),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .result_data_i  (result_o.data)
);

FILE: tb/stick_snapback_suppressor_tb.sv
module stick_snapback_suppressor_tb;
  import ssb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PIPE_CYCLES   = 2;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ssb_sample_if sample_ch ();
  ssb_result_if result_ch ();

  stick_snapback_suppressor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_ch),
    .result_o   (result_ch)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // register copy used for prediction
  logic [AXIS_W-1:0] cfg_center;
  logic [AXIS_W-1:0] cfg_large;
  logic [AXIS_W-1:0] cfg_small;
  logic [TIME_W-1:0] cfg_release;
  logic [TIME_W-1:0] cfg_correct;
  logic              cfg_left_on;
  logic              cfg_right_on;

  // per-axis suppression state
  logic [TIME_W-1:0] large_seen_at [AXES];
  logic [TIME_W-1:0] hold_since    [AXES];
  logic              holding       [AXES];

  sample_t pending_samples [$];
  result_t expected_outputs [$];

  int          samples_queued   = 0;
  int          results_seen     = 0;
  int          error_count      = 0;
  int          cycle_count      = 0;
  int          settings_applied = 0;
  int          holds_started    = 0;
  int          holds_ended      = 0;
  int          send_idle_pct    = 0;
  int          recv_idle_pct    = 0;
  logic        sample_moved     = 1'b0;
  logic [TIME_W-1:0] stamp_now  = '0;

  task automatic flag_error(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("ERROR @%0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // register model
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_CENTER:      cfg_center   = value[AXIS_W-1:0];
      CFG_LARGE_TH:    cfg_large    = value[AXIS_W-1:0];
      CFG_SMALL_TH:    cfg_small    = value[AXIS_W-1:0];
      CFG_RELEASE_WIN: cfg_release  = value[TIME_W-1:0];
      CFG_CORRECT_WIN: cfg_correct  = value[TIME_W-1:0];
      CFG_LEFT_EN:     cfg_left_on  = value[0];
      CFG_RIGHT_EN:    cfg_right_on = value[0];
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    cfg_center   = CENTER_RST;
    cfg_large    = LARGE_TH_RST;
    cfg_small    = SMALL_TH_RST;
    cfg_release  = RELEASE_WIN_RST;
    cfg_correct  = CORRECT_WIN_RST;
    cfg_left_on  = 1'b1;
    cfg_right_on = 1'b1;
    for (int k = 0; k < AXES; k++) begin
      large_seen_at[k] = '0;
      hold_since[k]    = '0;
      holding[k]       = 1'b0;
    end
  endfunction

  // one axis: track large deflections, start and end the snapback hold
  function automatic logic [AXIS_W-1:0] track_axis(input int k,
                                                   input logic [TIME_W-1:0] stamp,
                                                   input logic [AXIS_W-1:0] pos);
    logic [AXIS_W-1:0] offset;
    logic [TIME_W-1:0] since_large;
    logic [TIME_W-1:0] held_for;
    offset = (pos >= cfg_center) ? pos - cfg_center : cfg_center - pos;
    if (offset >= cfg_large) begin
      large_seen_at[k] = stamp;
    end
    since_large = stamp - large_seen_at[k];
    held_for    = stamp - hold_since[k];
    if (offset <= cfg_small) begin
      if (holding[k]) begin
        if (held_for > cfg_correct) begin
          holding[k] = 1'b0;
          holds_ended++;
        end
      end else if (since_large <= cfg_release) begin
        holding[k]    = 1'b1;
        hold_since[k] = stamp;
        holds_started++;
      end
    end else if (holding[k]) begin
      holding[k] = 1'b0;
      holds_ended++;
    end
    return holding[k] ? cfg_center : pos;
  endfunction

  function automatic result_t predict_sample(input sample_t s);
    result_t r;
    r.out_left_x  = cfg_left_on  ? track_axis(AX_LX, s.sample_time, s.left_x)  : cfg_center;
    r.out_left_y  = cfg_left_on  ? track_axis(AX_LY, s.sample_time, s.left_y)  : cfg_center;
    r.out_right_x = cfg_right_on ? track_axis(AX_RX, s.sample_time, s.right_x) : cfg_center;
    r.out_right_y = cfg_right_on ? track_axis(AX_RY, s.sample_time, s.right_y) : cfg_center;
    return r;
  endfunction

  task automatic check_axis(input string name, input logic [AXIS_W-1:0] got,
                            input logic [AXIS_W-1:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d %s: got %0d, expected %0d",
                           results_seen, name, got, want));
    end
  endtask

  // monitor: check result transfers, predict on sample transfers
  always @(posedge clk_i) begin : watch_channels
    result_t got;
    result_t want;
    if (!rst_ni) begin
      sample_moved = 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        results_seen++;
        if (expected_outputs.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: %h",
                               results_seen, got));
        end else begin
          want = expected_outputs.pop_front();
          check_axis("out_left_x",  got.out_left_x,  want.out_left_x);
          check_axis("out_left_y",  got.out_left_y,  want.out_left_y);
          check_axis("out_right_x", got.out_right_x, want.out_right_x);
          check_axis("out_right_y", got.out_right_y, want.out_right_y);
        end
      end
      sample_moved = sample_ch.valid && sample_ch.ready;
      if (sample_moved) begin
        expected_outputs.push_back(predict_sample(sample_ch.data));
      end
    end
  end

  // driver: present queued samples and toggle result ready
  always @(negedge clk_i) begin : drive_channels
    logic    nxt_valid;
    sample_t nxt_data;
    if (rst_ni) begin
      nxt_valid = sample_ch.valid;
      nxt_data  = sample_ch.data;
      if (!sample_ch.valid || sample_moved) begin
        nxt_valid = 1'b0;
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt_valid = 1'b1;
          nxt_data  = pending_samples.pop_front();
        end
      end
      sample_ch.valid <= nxt_valid;
      sample_ch.data  <= nxt_data;
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, results_seen, samples_queued);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    apply_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] center,
                               input logic [CFG_DATA_W-1:0] large_th,
                               input logic [CFG_DATA_W-1:0] small_th,
                               input logic [CFG_DATA_W-1:0] release_win,
                               input logic [CFG_DATA_W-1:0] correct_win,
                               input logic [CFG_DATA_W-1:0] left_on,
                               input logic [CFG_DATA_W-1:0] right_on);
    write_reg(CFG_CENTER,      center);
    write_reg(CFG_LARGE_TH,    large_th);
    write_reg(CFG_SMALL_TH,    small_th);
    write_reg(CFG_RELEASE_WIN, release_win);
    write_reg(CFG_CORRECT_WIN, correct_win);
    write_reg(CFG_LEFT_EN,     left_on);
    write_reg(CFG_RIGHT_EN,    right_on);
    settings_applied++;
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic wait_idle();
    while (results_seen < samples_queued) begin
      @(negedge clk_i);
    end
    repeat (PIPE_CYCLES + 2) @(negedge clk_i);
  endtask

  task automatic queue_sample(input logic [TIME_W-1:0] stamp,
                              input logic [AXIS_W-1:0] lx, input logic [AXIS_W-1:0] ly,
                              input logic [AXIS_W-1:0] rx, input logic [AXIS_W-1:0] ry);
    sample_t s;
    s.sample_time = stamp;
    s.left_x      = lx;
    s.left_y      = ly;
    s.right_x     = rx;
    s.right_y     = ry;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // axis value near, far or between the thresholds, sometimes anywhere
  function automatic logic [AXIS_W-1:0] pick_axis();
    int cat;
    int lo;
    int hi;
    int offset;
    int pos;
    cat = $urandom_range(0, 99);
    if (cat >= 80) begin
      return AXIS_W'($urandom_range(0, 4095));
    end
    if (cat < 40) begin
      lo = 0;
      hi = cfg_small;
    end else if (cat < 65) begin
      lo = cfg_large;
      hi = 4095;
    end else begin
      lo = cfg_small;
      hi = cfg_large;
    end
    offset = $urandom_range(lo, hi);
    pos  = $urandom_range(0, 1) ? int'(cfg_center) + offset : int'(cfg_center) - offset;
    if (pos < 0 || pos > 4095) begin
      pos = 2 * int'(cfg_center) - pos;
    end
    if (pos < 0) pos = 0;
    if (pos > 4095) pos = 4095;
    return pos[AXIS_W-1:0];
  endfunction

  // gesture-like samples: mostly short time steps scaled to the windows
  task automatic queue_random_samples(input int count);
    longint widest;
    int     span;
    int     r;
    widest = (cfg_release > cfg_correct) ? cfg_release : cfg_correct;
    if (widest == 0) begin
      span = 3;
    end else if (widest > 40000) begin
      span = 15000;
    end else begin
      span = int'(widest / 2) + 1;
    end
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        stamp_now = stamp_now;
      end else if (r < 75) begin
        stamp_now += $urandom_range(1, span);
      end else if (r < 95) begin
        stamp_now += $urandom_range(span, 3 * span);
      end else begin
        stamp_now = $urandom;
      end
      queue_sample(stamp_now, pick_axis(), pick_axis(), pick_axis(), pick_axis());
    end
  endtask

  // one register setting: half the samples, drain, the other half, drain
  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stamp_now = $urandom_range(0, 3) == 0 ? 32'hFFFF_F000 : $urandom;
    queue_random_samples(count / 2);
    wait_idle();
    queue_random_samples(count - count / 2);
    wait_idle();
  endtask

  initial begin
    int lo_th;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    result_ch.ready = 1'b0;
    reset_model();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: thresholds, windows and wrap at reset settings
    send_idle_pct = 26;
    recv_idle_pct = 57;
    queue_sample(0,      2048, 2048, 2048, 2048);
    queue_sample(100,    0,    4095, 4095, 0);
    queue_sample(200,    2148, 1948, 2048, 2049);
    queue_sample(5000,   1000, 2048, 3000, 2048);
    queue_sample(10200,  2048, 2048, 2048, 2048);
    queue_sample(10201,  2048, 2048, 2048, 2048);
    queue_sample(10300,  3548, 548,  2048, 2048);
    queue_sample(32'hFFFF_FF00, 4095, 0, 0, 4095);
    queue_sample(32'h0000_0100, 2048, 2048, 2048, 2048);
    queue_sample(32'h0000_0100 + 10001, 2048, 2048, 2048, 2048);
    queue_sample(20000,  4095, 0,    48,   4095);
    queue_sample(25001,  2048, 2048, 2048, 2048);
    queue_sample(30000,  0,    4095, 48,   4048);
    queue_sample(35000,  2048, 2048, 2048, 2048);
    queue_sample(35001,  3248, 848,  3248, 848);
    queue_sample(35002,  3249, 847,  2048, 2048);
    queue_sample(36000,  4095, 4095, 4095, 4095);
    queue_sample(36000,  2048, 2048, 2048, 2048);
    wait_idle();

    // disabled sticks, wide write data and an unused register index
    write_reg(CFG_LEFT_EN, 32'h0000_0002);
    queue_sample(40000, 4095, 0, 4095, 0);
    queue_sample(40100, 2048, 2048, 2048, 2048);
    wait_idle();
    write_reg(CFG_LEFT_EN, 32'h1);
    write_reg(CFG_RIGHT_EN, 32'h0);
    queue_sample(50000, 4095, 0, 4095, 0);
    queue_sample(50100, 2048, 2048, 2048, 2048);
    wait_idle();
    write_reg(CFG_RIGHT_EN, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_IDX, 32'h0);
    queue_sample(60000, 4095, 0, 4095, 0);
    queue_sample(60100, 2100, 2000, 2048, 2048);
    wait_idle();

    // random part, sender and receiver idling as set per phase
    run_phase(26, 57, 220);
    apply_setting(32'hFFFF_F000, 4095, 0, 0, 0, 1, 1);
    run_phase(26, 57, 220);
    apply_setting(4095, 0, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
    run_phase(57, 26, 200);
    apply_setting(1500, 600, 300, 300, 700, 0, 1);
    run_phase(57, 26, 220);
    apply_setting(2600, 1000, 1100, 2000, 1000, 1, 0);
    run_phase(0, 0, 220);
    lo_th = $urandom_range(0, 1500);
    apply_setting($urandom_range(0, 4095), lo_th + $urandom_range(1, 1500), lo_th,
                  $urandom_range(100, 8000), $urandom_range(100, 16000), 1, 1);
    run_phase(0, 0, 220);

    wait_idle();
    if (expected_outputs.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", expected_outputs.size()));
    end
    $display("checked %0d results from %0d samples across %0d register settings",
             results_seen, samples_queued, settings_applied + 1);
    $display("axis holds predicted: %0d started, %0d ended; %0d mismatches",
             holds_started, holds_ended, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
